@@ rtl/core/imu_six_axis_moving_average_unit_macros.svh @@
// Assertion helpers for the moving-average unit.
// Both sample on the rising edge of clk_i and stay quiet while rst_ni is low.
`ifndef IMU_SIX_AXIS_MOVING_AVERAGE_UNIT_MACROS_SVH
`define IMU_SIX_AXIS_MOVING_AVERAGE_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMUAVG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IMUAVG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/imuavg_pkg.sv @@
package imuavg_pkg;

  // Number of samples averaged per axis.
  localparam int unsigned WINDOW     = 8;

  localparam int unsigned AXES       = 6;
  localparam int unsigned ACCEL_AXES = 3;
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned GAIN_W     = 24;
  localparam int unsigned OUT_W      = 32;
  localparam int unsigned FRAC_BITS  = 8;
  localparam int unsigned DATA_W     = 32;
  localparam int unsigned WIDE_W     = 64;

  localparam int unsigned AXIS_W     = $clog2(AXES);
  localparam int unsigned WP_W       = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W      = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W      = RAW_W + $clog2(WINDOW);
  localparam int unsigned RING_DEPTH = AXES * WINDOW;
  localparam int unsigned ADDR_W     = $clog2(RING_DEPTH);
  localparam int unsigned PROD_W     = SUM_W + GAIN_W;
  localparam int unsigned QUO_W      = PROD_W - FRAC_BITS;

  // The divider retires this many quotient bits per cycle.
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_STEPS  = (QUO_W + DIV_BITS - 1) / DIV_BITS;
  localparam int unsigned DIV_W      = DIV_STEPS * DIV_BITS;
  localparam int unsigned STEP_W     = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  localparam int unsigned CFG_REGS   = 2;
  localparam int unsigned PADDR_W    = $clog2(CFG_REGS * 4);
  localparam int unsigned CFG_IDX_W  = PADDR_W - 2;

  typedef logic signed [RAW_W-1:0] raw_t;
  typedef logic signed [OUT_W-1:0] avg_t;
  typedef logic [GAIN_W-1:0]       gain_t;

  localparam gain_t ACCEL_GAIN_RST = 24'd7995;
  localparam gain_t GYRO_GAIN_RST  = 24'd4588;

  localparam avg_t AVG_MAX = 32'sh7FFF_FFFF;
  localparam avg_t AVG_MIN = 32'sh8000_0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACCEL_GAIN = 1'd0,
    CFG_GYRO_GAIN  = 1'd1
  } cfg_idx_e;

endpackage

@@ rtl/core/imuavg_if.sv @@
interface imuavg_in_if;
  import imuavg_pkg::*;

  logic valid;
  logic ready;
  raw_t accel_x_raw;
  raw_t accel_y_raw;
  raw_t accel_z_raw;
  raw_t gyro_x_raw;
  raw_t gyro_y_raw;
  raw_t gyro_z_raw;

  modport source (
    output valid, accel_x_raw, accel_y_raw, accel_z_raw,
    output gyro_x_raw, gyro_y_raw, gyro_z_raw,
    input  ready
  );

  modport sink (
    input  valid, accel_x_raw, accel_y_raw, accel_z_raw,
    input  gyro_x_raw, gyro_y_raw, gyro_z_raw,
    output ready
  );
endinterface

interface imuavg_out_if;
  import imuavg_pkg::*;

  logic valid;
  logic ready;
  avg_t accel_x_avg;
  avg_t accel_y_avg;
  avg_t accel_z_avg;
  avg_t gyro_x_avg;
  avg_t gyro_y_avg;
  avg_t gyro_z_avg;

  modport source (
    output valid, accel_x_avg, accel_y_avg, accel_z_avg,
    output gyro_x_avg, gyro_y_avg, gyro_z_avg,
    input  ready
  );

  modport sink (
    input  valid, accel_x_avg, accel_y_avg, accel_z_avg,
    input  gyro_x_avg, gyro_y_avg, gyro_z_avg,
    output ready
  );
endinterface

@@ rtl/core/imu_six_axis_moving_average_unit.sv @@
// A new sample is taken only when the sequencer is idle, after the previous sequence
// has finished; the shared radix-16 divider works through the six axes one after
// another. The sequence stalls before returning to idle while the previous result
// still waits in the output register.
// Reset (rst_ni low, asynchronous) empties the window and restores both gains; the
// sample memory keeps its contents and needs no clearing pass.
`include "imu_six_axis_moving_average_unit_macros.svh"

module imu_six_axis_moving_average_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  imuavg_in_if.sink                       sample_i,
  imuavg_out_if.source                    result_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [imuavg_pkg::PADDR_W-1:0]  paddr,
  input  logic [imuavg_pkg::DATA_W-1:0]   pwdata,
  output logic [imuavg_pkg::DATA_W-1:0]   prdata,
  output logic                            pready
);
  import imuavg_pkg::*;

  // The sequencer walks each axis through read, update, multiply, divide and
  // saturate. Only one axis is in flight, so a memory entry is never read while
  // a write to it is still pending.
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_UPD  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_DIV  = 7'b0010000,
    S_SAT  = 7'b0100000,
    S_DONE = 7'b1000000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  gain_t    accel_gain_q;
  gain_t    gyro_gain_q;
  logic     cfg_we;
  cfg_idx_e cfg_idx;

  // Window bookkeeping, shared by all six axes.
  logic [CNT_W-1:0]  fill_q;
  logic [WP_W-1:0]   wp_q;
  logic [WP_W-1:0]   slot_q;
  logic              first_q;
  logic              full_q;
  logic [AXIS_W-1:0] axis_q;
  logic [STEP_W-1:0] step_q;

  // Sample held for the whole sequence.
  raw_t raw_q [AXES];

  // Ring of past samples and the running sums, both in synchronous memories.
  raw_t                   ring_mem [RING_DEPTH];
  logic signed [SUM_W-1:0] sum_mem [AXES];
  logic [ADDR_W-1:0]      ring_addr;
  raw_t                   ring_rd_q;
  logic signed [SUM_W-1:0] sum_rd_q;
  logic signed [SUM_W-1:0] sum_base;
  logic signed [SUM_W-1:0] sum_sub;
  logic signed [SUM_W-1:0] sum_new;
  logic signed [SUM_W-1:0] sum_q;

  // Scaling and division.
  logic [SUM_W-1:0]  mag;
  gain_t             gain_sel;
  logic [PROD_W-1:0] prod;
  logic              neg_q;
  logic [DIV_W-1:0]  quo_q, quo_nx;
  logic [CNT_W-1:0]  rem_q, rem_nx;
  logic [CNT_W:0]    rem_w;
  logic [WIDE_W-1:0] quo_wide;
  logic              pos_ovf;
  logic              neg_ovf;
  avg_t              sat_val;

  // Finished averages and the output register.
  avg_t res_q [AXES];
  avg_t avg_q [AXES];
  logic out_valid_q;
  logic out_free;
  logic in_fire;

  // ---------------------------------------------------------------------------
  // Configuration port. Writes complete in the access phase; pready is tied high.
  // ---------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = cfg_idx_e'(paddr[PADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accel_gain_q <= ACCEL_GAIN_RST;
      gyro_gain_q  <= GYRO_GAIN_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_ACCEL_GAIN: accel_gain_q <= pwdata[GAIN_W-1:0];
        CFG_GYRO_GAIN:  gyro_gain_q  <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      CFG_ACCEL_GAIN: prdata = DATA_W'(accel_gain_q);
      CFG_GYRO_GAIN:  prdata = DATA_W'(gyro_gain_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Handshakes. A new sample is taken only when the sequencer is idle, but the
  // previous result may still be waiting in the output register at that time.
  // ---------------------------------------------------------------------------
  assign sample_i.ready = (state_q == S_IDLE);
  assign in_fire        = sample_i.valid && sample_i.ready;
  assign out_free       = !out_valid_q || result_o.ready;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_fire) state_d = S_READ;
      S_READ: state_d = S_UPD;
      S_UPD:  state_d = S_MUL;
      S_MUL:  state_d = S_DIV;
      S_DIV:  if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = S_SAT;
      S_SAT: begin
        if (axis_q == AXIS_W'(AXES - 1)) begin
          state_d = S_DONE;
        end else begin
          state_d = S_READ;
        end
      end
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control state. The write pointer and fill count advance when the sample is
  // taken; the old values are kept as slot, first and full for the sequence.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      fill_q      <= '0;
      wp_q        <= '0;
      slot_q      <= '0;
      first_q     <= 1'b0;
      full_q      <= 1'b0;
      axis_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_fire) begin
        axis_q  <= '0;
        slot_q  <= wp_q;
        first_q <= (fill_q == '0);
        full_q  <= (fill_q == CNT_W'(WINDOW));
        if (wp_q == WP_W'(WINDOW - 1)) begin
          wp_q <= '0;
        end else begin
          wp_q <= wp_q + 1'b1;
        end
        if (fill_q != CNT_W'(WINDOW)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (state_q == S_MUL) begin
        step_q <= '0;
      end else if (state_q == S_DIV) begin
        step_q <= step_q + 1'b1;
      end
      if ((state_q == S_SAT) && (axis_q != AXIS_W'(AXES - 1))) begin
        axis_q <= axis_q + 1'b1;
      end
      if ((state_q == S_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Memories. Both are read in the read state and written back in the following cycle
  // at the same address, in the update state.
  // ---------------------------------------------------------------------------
  assign ring_addr = ADDR_W'(axis_q) * ADDR_W'(WINDOW) + ADDR_W'(slot_q);

  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD) begin
      ring_mem[ring_addr] <= raw_q[axis_q];
    end
    if (state_q == S_READ) begin
      ring_rd_q <= ring_mem[ring_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_UPD) begin
      sum_mem[axis_q] <= sum_new;
    end
    if (state_q == S_READ) begin
      sum_rd_q <= sum_mem[axis_q];
    end
  end

  // For the first sample after reset the stored sum is ignored, which stands in
  // for clearing the sum memory. The oldest sample leaves the sum only once the
  // window is full, so unwritten ring entries never count.
  always_comb begin
    sum_base = first_q ? '0 : sum_rd_q;
    sum_sub  = full_q ? SUM_W'(ring_rd_q) : '0;
    sum_new  = sum_base - sum_sub + SUM_W'(raw_q[axis_q]);
  end

  // Magnitude times gain; the sign is reapplied after the division.
  always_comb begin
    mag      = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
    gain_sel = (axis_q < AXIS_W'(ACCEL_AXES)) ? accel_gain_q : gyro_gain_q;
    prod     = PROD_W'(mag) * PROD_W'(gain_sel);
  end

  // Restoring division by the fill count, several quotient bits per cycle. The
  // Q.8 scaling is folded in by dropping the low fraction bits of the product.
  always_comb begin
    quo_nx = quo_q;
    rem_nx = rem_q;
    rem_w  = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      rem_w  = {rem_nx, quo_nx[DIV_W-1]};
      quo_nx = {quo_nx[DIV_W-2:0], 1'b0};
      if (rem_w >= {1'b0, fill_q}) begin
        rem_w     = rem_w - {1'b0, fill_q};
        quo_nx[0] = 1'b1;
      end
      rem_nx = rem_w[CNT_W-1:0];
    end
  end

  // Saturate the truncated magnitude to the signed 32-bit range.
  always_comb begin
    quo_wide = WIDE_W'(quo_q);
    pos_ovf  = quo_wide > 64'h0000_0000_7FFF_FFFF;
    neg_ovf  = quo_wide > 64'h0000_0000_8000_0000;
    if (neg_q) begin
      sat_val = neg_ovf ? AVG_MIN : -avg_t'(quo_wide[OUT_W-1:0]);
    end else begin
      sat_val = pos_ovf ? AVG_MAX : avg_t'(quo_wide[OUT_W-1:0]);
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      raw_q[0] <= sample_i.accel_x_raw;
      raw_q[1] <= sample_i.accel_y_raw;
      raw_q[2] <= sample_i.accel_z_raw;
      raw_q[3] <= sample_i.gyro_x_raw;
      raw_q[4] <= sample_i.gyro_y_raw;
      raw_q[5] <= sample_i.gyro_z_raw;
    end
    if (state_q == S_UPD) begin
      sum_q <= sum_new;
    end
    if (state_q == S_MUL) begin
      neg_q <= sum_q[SUM_W-1];
      quo_q <= DIV_W'(prod[PROD_W-1:FRAC_BITS]);
      rem_q <= '0;
    end
    if (state_q == S_DIV) begin
      quo_q <= quo_nx;
      rem_q <= rem_nx;
    end
    if (state_q == S_SAT) begin
      res_q[axis_q] <= sat_val;
    end
    if ((state_q == S_DONE) && out_free) begin
      for (int a = 0; a < AXES; a++) begin
        avg_q[a] <= res_q[a];
      end
    end
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.accel_x_avg = avg_q[0];
  assign result_o.accel_y_avg = avg_q[1];
  assign result_o.accel_z_avg = avg_q[2];
  assign result_o.gyro_x_avg  = avg_q[3];
  assign result_o.gyro_y_avg  = avg_q[4];
  assign result_o.gyro_z_avg  = avg_q[5];

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `IMUAVG_ASSERT_NEXT(a_fill_advance, in_fire && (fill_q != CNT_W'(WINDOW)), fill_q == $past(fill_q) + 1'b1, "fill count did not advance on a new sample")
  `IMUAVG_ASSERT_SAME(a_div_nonzero, state_q == S_DIV, fill_q != '0, "divider running with a zero fill count")
  `IMUAVG_ASSERT_NEXT(a_result_loaded, (state_q == S_DONE) && out_free, out_valid_q && (state_q == S_IDLE), "finished averages not moved to the output register")

endmodule
